// ----- rtl/kbr_pkg.sv -----
package kbr_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int SLOT_CAP = 6;
  localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

  typedef enum logic [1:0] {
    KIND_PRESS    = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_MODIFIER = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_data;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       code;
  } store_cmd_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       hit;
    logic       empty;
  } store_stat_t;

endpackage

// ----- rtl/kbr_if.sv -----
interface kbr_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] key_code;
  logic [7:0] modifier_bits;

  modport source (output valid, kind, key_code, modifier_bits, input ready);
  modport sink (input valid, kind, key_code, modifier_bits, output ready);
endinterface

interface kbr_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_modifiers;
  logic [7:0] slot_zero;
  logic [7:0] slot_one;
  logic [7:0] slot_two;
  logic [7:0] slot_three;
  logic [7:0] slot_four;
  logic [7:0] slot_five;

  modport source (output valid, report_modifiers, slot_zero, slot_one, slot_two,
                  slot_three, slot_four, slot_five, input ready);
  modport sink (input valid, report_modifiers, slot_zero, slot_one, slot_two,
                slot_three, slot_four, slot_five, output ready);
endinterface

// ----- rtl/kbr_key_store.sv -----
module kbr_key_store (
  input  logic                                   clk,
  input  logic                                   rst,
  input  kbr_pkg::store_cmd_t                    cmd,
  output kbr_pkg::store_stat_t                   stat,
  output logic [kbr_pkg::SLOT_CAP-1:0][7:0]      keys
);

  logic [7:0] slots [kbr_pkg::KEY_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kbr_pkg::KEY_SLOTS; i++) begin
        slots[i] <= 8'd0;
      end
    end else if (cmd.wr_en) begin
      slots[cmd.wr_idx] <= cmd.wr_data;
    end
  end

  always_comb begin
    stat.rd_data = slots[cmd.rd_idx];
    stat.hit     = (stat.rd_data == cmd.code);
    stat.empty   = (stat.rd_data == 8'd0);
  end

  for (genvar k = 0; k < kbr_pkg::SLOT_CAP; k++) begin : g_key
    if (k < kbr_pkg::KEY_SLOTS) begin : g_used
      assign keys[k] = slots[k];
    end else begin : g_unused
      assign keys[k] = 8'd0;
    end
  end

endmodule

// ----- rtl/keyboard_report_key_array.sv -----
// Channel     Direction  Fields
// key_event   in         kind, key_code, modifier_bits
// report      out        report_modifiers, slot_zero .. slot_five
//
// A modifier update that changes the bitmap goes from the transfer to the emit state, which loads the report.
// A key press or release walks the slots one per cycle through a single
// compare unit in the scan state, then goes on to the tail (release only) and emit states.
// Reset clears every slot and the modifier bitmap at once.
// A new event is taken whenever the sequencer is idle, even while a report
// waits; a finished report waits in its own state only while the output
// register still holds one that has not been taken.
module keyboard_report_key_array (
  input logic           clk,
  input logic           rst,
  kbr_event_if.sink     key_event,
  kbr_report_if.source  report
);

  kbr_pkg::state_t state;
  kbr_pkg::state_t state_next;

  logic [1:0]                kind;
  logic [7:0]                code;
  logic [7:0]                modifier_state;
  logic [kbr_pkg::IDX_W-1:0] idx;
  logic [kbr_pkg::IDX_W-1:0] idx_next;
  logic [kbr_pkg::IDX_W-1:0] wr_ptr;
  logic [kbr_pkg::IDX_W-1:0] wr_ptr_next;
  logic                      found;
  logic                      found_next;
  logic                      load_out;
  logic                      out_valid;

  logic [7:0]                              out_mods;
  logic [kbr_pkg::SLOT_CAP-1:0][7:0]       out_keys;
  logic [kbr_pkg::SLOT_CAP-1:0][7:0]       keys;

  kbr_pkg::store_cmd_t  cmd;
  kbr_pkg::store_stat_t stat;

  logic accept;
  logic is_release;
  logic at_last;

  assign accept     = key_event.valid && key_event.ready;
  assign is_release = (kind == kbr_pkg::KIND_RELEASE);
  assign at_last    = (idx == kbr_pkg::LAST_IDX);

  kbr_key_store u_store (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .keys (keys)
  );

  always_comb begin
    state_next = state;
    case (state)
      kbr_pkg::ST_IDLE: begin
        if (accept) begin
          case (key_event.kind)
            kbr_pkg::KIND_PRESS, kbr_pkg::KIND_RELEASE: begin
              if (key_event.key_code != 8'd0) begin
                state_next = kbr_pkg::ST_SCAN;
              end
            end
            kbr_pkg::KIND_MODIFIER: begin
              if (key_event.modifier_bits != modifier_state) begin
                state_next = kbr_pkg::ST_EMIT;
              end
            end
            default: state_next = kbr_pkg::ST_IDLE;
          endcase
        end
      end
      kbr_pkg::ST_SCAN: begin
        if (!is_release) begin
          if (stat.hit) begin
            state_next = kbr_pkg::ST_IDLE;
          end else if (stat.empty) begin
            state_next = kbr_pkg::ST_EMIT;
          end else if (at_last) begin
            state_next = kbr_pkg::ST_IDLE;
          end
        end else if (stat.empty) begin
          state_next = found ? kbr_pkg::ST_TAIL : kbr_pkg::ST_IDLE;
        end else if (at_last) begin
          state_next = (found || stat.hit) ? kbr_pkg::ST_TAIL : kbr_pkg::ST_IDLE;
        end
      end
      kbr_pkg::ST_TAIL: state_next = kbr_pkg::ST_EMIT;
      kbr_pkg::ST_EMIT: begin
        if (!out_valid || report.ready) begin
          state_next = kbr_pkg::ST_IDLE;
        end
      end
      default: state_next = kbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    key_event.ready = (state == kbr_pkg::ST_IDLE);
    idx_next        = idx;
    wr_ptr_next     = wr_ptr;
    found_next      = found;
    load_out        = 1'b0;
    cmd.wr_en       = 1'b0;
    cmd.wr_idx      = wr_ptr;
    cmd.wr_data     = stat.rd_data;
    cmd.rd_idx      = idx;
    cmd.code        = code;
    case (state)
      kbr_pkg::ST_IDLE: begin
        idx_next    = '0;
        wr_ptr_next = '0;
        found_next  = 1'b0;
      end
      kbr_pkg::ST_SCAN: begin
        if (!is_release) begin
          if (!stat.hit && stat.empty) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_idx  = idx;
            cmd.wr_data = code;
          end
        end else if (!stat.empty) begin
          if (stat.hit) begin
            found_next = 1'b1;
          end else begin
            cmd.wr_en   = 1'b1;
            wr_ptr_next = wr_ptr + 1'b1;
          end
        end
        if (!at_last) begin
          idx_next = idx + 1'b1;
        end
      end
      kbr_pkg::ST_TAIL: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_data = 8'd0;
      end
      kbr_pkg::ST_EMIT: begin
        load_out = !out_valid || report.ready;
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= kbr_pkg::ST_IDLE;
      modifier_state <= 8'd0;
      out_valid      <= 1'b0;
      idx            <= '0;
      wr_ptr         <= '0;
      found          <= 1'b0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      wr_ptr <= wr_ptr_next;
      found  <= found_next;
      if (accept && key_event.kind == kbr_pkg::KIND_MODIFIER) begin
        modifier_state <= key_event.modifier_bits;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= key_event.kind;
      code <= key_event.key_code;
    end
    if (load_out) begin
      out_mods <= modifier_state;
      out_keys <= keys;
    end
  end

  assign report.valid            = out_valid;
  assign report.report_modifiers = out_mods;
  assign report.slot_zero        = out_keys[0];
  assign report.slot_one         = out_keys[1];
  assign report.slot_two         = out_keys[2];
  assign report.slot_three       = out_keys[3];
  assign report.slot_four        = out_keys[4];
  assign report.slot_five        = out_keys[5];

  a_wr_behind: assert property (@(posedge clk) disable iff (rst)
    state == kbr_pkg::ST_SCAN |-> wr_ptr <= idx)
    else $error("compaction pointer ran ahead of the scan");

  a_tail_found: assert property (@(posedge clk) disable iff (rst)
    state == kbr_pkg::ST_TAIL |-> found && wr_ptr <= kbr_pkg::LAST_IDX)
    else $error("tail clear without a removed key");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == kbr_pkg::ST_SCAN |-> idx <= kbr_pkg::LAST_IDX)
    else $error("scan index beyond the last slot");

  a_load_frees: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && state == kbr_pkg::ST_IDLE)
    else $error("report load did not return the sequencer to idle");

endmodule

// ----- test/keyboard_report_key_array_tb.sv -----
`timescale 1ns / 100ps

module keyboard_report_key_array_tb;

  localparam int USED_SLOTS = (kbr_pkg::KEY_SLOTS > kbr_pkg::SLOT_CAP) ? kbr_pkg::SLOT_CAP
                              : ((kbr_pkg::KEY_SLOTS < 1) ? 1 : kbr_pkg::KEY_SLOTS);
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_EVENTS = 1080;
  localparam int SETTLE_CYCLES = kbr_pkg::KEY_SLOTS + 8;
  localparam int DRAIN_LIMIT = 4000;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] code;
    logic [7:0] mods;
    bit         drain_first;
  } key_event_t;

  typedef struct packed {
    logic [7:0]                         mods;
    logic [kbr_pkg::SLOT_CAP-1:0][7:0]  slots;
  } kbd_report_t;

  logic clk;
  logic rst;

  kbr_event_if  key_ev ();
  kbr_report_if rpt ();

  keyboard_report_key_array DUT (
    .clk       (clk),
    .rst       (rst),
    .key_event (key_ev),
    .report    (rpt)
  );

  key_event_t  pending_events [$];
  kbd_report_t expected_reports [$];

  logic [7:0] held_keys [kbr_pkg::SLOT_CAP];
  logic [7:0] held_mods;

  int error_count;
  int events_taken;
  int reports_due;
  int reports_seen;
  int tx_idle_pct;
  int rx_idle_pct;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic bit apply_event(input logic [1:0] kind, input logic [7:0] code,
                                     input logic [7:0] mods, output kbd_report_t rep);
    int  hit;
    int  free_slot;
    bit  changed;
    hit = -1;
    free_slot = -1;
    changed = 1'b0;
    for (int i = 0; i < USED_SLOTS; i++) begin
      if (held_keys[i] == 8'd0) begin
        if (free_slot < 0) free_slot = i;
      end else if (held_keys[i] == code && free_slot < 0) begin
        hit = i;
      end
    end
    case (kind)
      kbr_pkg::KIND_PRESS: begin
        if (code != 8'd0 && hit < 0 && free_slot >= 0) begin
          held_keys[free_slot] = code;
          changed = 1'b1;
        end
      end
      kbr_pkg::KIND_RELEASE: begin
        if (code != 8'd0 && hit >= 0) begin
          for (int i = hit; i < USED_SLOTS - 1; i++) held_keys[i] = held_keys[i+1];
          held_keys[USED_SLOTS-1] = 8'd0;
          changed = 1'b1;
        end
      end
      kbr_pkg::KIND_MODIFIER: begin
        if (mods != held_mods) begin
          held_mods = mods;
          changed = 1'b1;
        end
      end
      default: ;
    endcase
    rep.mods = held_mods;
    for (int i = 0; i < kbr_pkg::SLOT_CAP; i++)
      rep.slots[i] = (i < USED_SLOTS) ? held_keys[i] : 8'd0;
    return changed;
  endfunction

  function automatic key_event_t make_event(input logic [1:0] kind, input logic [7:0] code,
                                            input logic [7:0] mods);
    key_event_t ev;
    ev.kind = kind;
    ev.code = code;
    ev.mods = mods;
    ev.drain_first = 1'b0;
    return ev;
  endfunction

  always @(posedge clk) begin
    kbd_report_t rep;
    key_event_t  nxt;
    bit          may_send;
    if (rst) begin
      key_ev.valid <= 1'b0;
      key_ev.kind <= kbr_pkg::KIND_PRESS;
      key_ev.key_code <= 8'd0;
      key_ev.modifier_bits <= 8'd0;
    end else begin
      if (key_ev.valid && key_ev.ready) begin
        if (apply_event(key_ev.kind, key_ev.key_code, key_ev.modifier_bits, rep)) begin
          expected_reports.push_back(rep);
          reports_due++;
        end
        events_taken <= events_taken + 1;
      end
      if (!key_ev.valid || key_ev.ready) begin
        may_send = pending_events.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct;
        if (may_send && pending_events[0].drain_first && reports_due != reports_seen)
          may_send = 1'b0;
        if (may_send) begin
          nxt = pending_events.pop_front();
          key_ev.valid <= 1'b1;
          key_ev.kind <= nxt.kind;
          key_ev.key_code <= nxt.code;
          key_ev.modifier_bits <= nxt.mods;
        end else begin
          key_ev.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    kbd_report_t got;
    kbd_report_t want;
    string       names [7];
    logic [7:0]  got_f [7];
    logic [7:0]  want_f [7];
    if (rst) begin
      rpt.ready <= 1'b0;
    end else begin
      if (rpt.valid && rpt.ready) begin
        reports_seen <= reports_seen + 1;
        got.mods = rpt.report_modifiers;
        got.slots[0] = rpt.slot_zero;
        got.slots[1] = rpt.slot_one;
        got.slots[2] = rpt.slot_two;
        got.slots[3] = rpt.slot_three;
        got.slots[4] = rpt.slot_four;
        got.slots[5] = rpt.slot_five;
        if (expected_reports.size() == 0) begin
          flag_error($sformatf("report %h with none expected", got));
        end else begin
          want = expected_reports.pop_front();
          names = '{"report_modifiers", "slot_zero", "slot_one", "slot_two",
                    "slot_three", "slot_four", "slot_five"};
          got_f[0] = got.mods;
          want_f[0] = want.mods;
          for (int i = 0; i < kbr_pkg::SLOT_CAP; i++) begin
            got_f[i+1] = got.slots[i];
            want_f[i+1] = want.slots[i];
          end
          for (int i = 0; i < 7; i++) begin
            if (got_f[i] !== want_f[i])
              flag_error($sformatf("%s got %h, want %h", names[i], got_f[i], want_f[i]));
          end
        end
      end
      rpt.ready <= $urandom_range(0, 99) >= rx_idle_pct;
    end
  end

  always @(posedge clk) begin
    if (events_taken < RANDOM_EVENTS / 3) begin
      tx_idle_pct <= 36;
      rx_idle_pct <= 65;
    end else if (events_taken < 2 * RANDOM_EVENTS / 3) begin
      tx_idle_pct <= 65;
      rx_idle_pct <= 36;
    end else begin
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
    end
  end

  initial begin
    logic [7:0] key_pool [10];
    logic [7:0] last_mods;
    logic [7:0] code;
    key_event_t ev;
    int         pick;
    int         waited;

    error_count = 0;
    events_taken = 0;
    reports_due = 0;
    reports_seen = 0;
    tx_idle_pct = 36;
    rx_idle_pct = 65;
    held_mods = 8'd0;
    for (int i = 0; i < kbr_pkg::SLOT_CAP; i++) held_keys[i] = 8'd0;
    key_ev.valid = 1'b0;
    key_ev.kind = kbr_pkg::KIND_PRESS;
    key_ev.key_code = 8'd0;
    key_ev.modifier_bits = 8'd0;
    rpt.ready = 1'b0;
    rst = 1'b1;

    pending_events.push_back(make_event(kbr_pkg::KIND_MODIFIER, 8'hFF, 8'h00));
    pending_events.push_back(make_event(KIND_UNUSED, 8'h11, 8'h5A));
    pending_events.push_back(make_event(kbr_pkg::KIND_PRESS, 8'h00, 8'hFF));
    pending_events.push_back(make_event(kbr_pkg::KIND_RELEASE, 8'h00, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_RELEASE, 8'h05, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_PRESS, 8'h01, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_PRESS, 8'hFF, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_PRESS, 8'h01, 8'hFF));
    pending_events.push_back(make_event(kbr_pkg::KIND_PRESS, 8'h04, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_PRESS, 8'h05, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_PRESS, 8'h06, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_PRESS, 8'h07, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_PRESS, 8'h08, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_RELEASE, 8'hFF, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_RELEASE, 8'h01, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_RELEASE, 8'h07, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_MODIFIER, 8'h00, 8'hFF));
    pending_events.push_back(make_event(kbr_pkg::KIND_MODIFIER, 8'h00, 8'hFF));
    pending_events.push_back(make_event(kbr_pkg::KIND_MODIFIER, 8'hFF, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_MODIFIER, 8'h00, 8'hA5));
    pending_events.push_back(make_event(kbr_pkg::KIND_PRESS, 8'h80, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_RELEASE, 8'h04, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_RELEASE, 8'h05, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_RELEASE, 8'h06, 8'h00));
    pending_events.push_back(make_event(kbr_pkg::KIND_RELEASE, 8'h80, 8'h00));

    for (int i = 0; i < 10; i++) key_pool[i] = 8'($urandom_range(1, 255));
    last_mods = 8'hA5;
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 200 == 0) begin
        for (int i = 0; i < 10; i++) key_pool[i] = 8'($urandom_range(1, 255));
      end
      code = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                          : key_pool[$urandom_range(0, 9)];
      ev = make_event(kbr_pkg::KIND_PRESS, code, 8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        ev.kind = kbr_pkg::KIND_PRESS;
      end else if (pick < 80) begin
        ev.kind = kbr_pkg::KIND_RELEASE;
      end else if (pick < 95) begin
        ev.kind = kbr_pkg::KIND_MODIFIER;
        if ($urandom_range(0, 3) == 0) ev.mods = last_mods;
        last_mods = ev.mods;
      end else if (pick < 97) begin
        ev.kind = KIND_UNUSED;
      end else begin
        ev.kind = ($urandom_range(0, 1) == 0) ? kbr_pkg::KIND_PRESS : kbr_pkg::KIND_RELEASE;
        ev.code = 8'd0;
      end
      if (n == 300 || n == 800) ev.drain_first = 1'b1;
      pending_events.push_back(ev);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_events.size() != 0 || key_ev.valid) @(posedge clk);
    waited = 0;
    while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_reports.size() != 0)
      flag_error($sformatf("%0d reports never arrived", expected_reports.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[keyboard_report_key_array] OK");
    end else begin
      $display("[keyboard_report_key_array] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[keyboard_report_key_array] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/kbr_pkg.sv
rtl/kbr_if.sv
rtl/kbr_key_store.sv
rtl/keyboard_report_key_array.sv
test/keyboard_report_key_array_tb.sv
